// ----- hdl/nntt_pkg.sv -----
// Shared types and constants of the nearest neighbour track table.
`timescale 1ns / 1ps
package nntt_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned DistW  = 34;
	localparam int unsigned AgeW   = 16;
	localparam int unsigned TickW  = 32;
	localparam int unsigned IdW    = 16;

	typedef enum logic [1:0] {
		OP_DETECT = 2'd0,
		OP_TICK   = 2'd1,
		OP_REPORT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_GATE   = 2'd0,
		REG_REPORT = 2'd1,
		REG_REMOVE = 2'd2,
		REG_NONE   = 2'd3
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MATCH,
		ST_CLOSE,
		ST_PURGE,
		ST_EMIT,
		ST_WAIT,
		ST_EMPTY
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;   // capture the request payload
		logic scan_clr;    // start a scan at slot zero
		logic scan_step;   // compare one slot, advance
		logic do_match;    // write detection into best slot or buffer it
		logic close_step;  // move one pending entry into the table
		logic purge_step;  // keep or drop one slot, advance
		logic purge_done;  // commit compacted count
		logic emit_step;   // test one slot for report, advance
		logic emit_load;   // load output register with the tested slot
		logic emit_empty;  // load output register with the empty marker
		logic tick;        // advance time
	} cmd_t;

	typedef struct packed {
		logic scan_end;    // scan index reached track count
		logic frame_end;   // captured frame_end bit
		logic close_end;   // all pending entries processed
		logic purge_end;   // purge index reached track count
		logic emit_end;    // emit index reached count or result limit
		logic emit_hit;    // slot under test is recent
		logic emitted_any; // at least one item went out
		logic [1:0] op;    // captured op code
	} stat_t;

endpackage

// ----- hdl/nearest_neighbour_track_table_core.sv -----
// Top level of the nearest neighbour track table.
`timescale 1ns / 1ps
// Gated nearest-neighbour track table. Requests enter on the s_axis group
// (x, y, z on tdata, op on tuser, frame_end on tlast) and report items leave
// on m_axis. The block works on one request at a time. A tick advances
// time. A detection scans the table one slot a cycle through one distance
// unit, then updates the best slot or buffers the detection; at frame end
// the buffered detections are moved into the table while there is room. A
// report runs a compaction sweep, then tests the surviving slots one a cycle
// while m_axis does not hold off, until 32 items are out, or sends an empty
// item if none is recent. Registers sit at byte addresses 0, 8 and 16 on a
// 64-bit APB port.
module nearest_neighbour_track_table_core #(
	parameter int unsigned TRACKS  = 32,
	parameter int unsigned PENDING = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // pos_x, pos_y, pos_z
	input  logic [1:0]  s_axis_tuser,  // op
	input  logic        s_axis_tlast,  // frame_end
	input  logic        m_axis_tready,
	output logic        m_axis_tvalid,
	output logic [63:0] m_axis_tdata,  // track_id, out_x, out_y, out_z
	output logic        m_axis_tuser,  // none_recent
	output logic        m_axis_tlast,  // last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [33:0] gate_q;
	logic [15:0] rep_q, rem_q;
	nntt_pkg::cmd_t  cmd;
	nntt_pkg::stat_t st;
	nntt_pkg::reg_t  reg_sel;
	logic out_busy, in_fire;
	logic [63:0] raw_data;
	logic raw_user, raw_last, raw_valid;

	assign pready = 1'b1;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// registers at 8*i since gate_sq exceeds 32 bits; drop unaligned access
	assign reg_sel = (paddr[2:0] == 3'd0) ? nntt_pkg::reg_t'(paddr[4:3]) : nntt_pkg::REG_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= 34'd65536;
			rep_q  <= 16'd50;
			rem_q  <= 16'd200;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				nntt_pkg::REG_GATE:   gate_q <= pwdata[33:0];
				nntt_pkg::REG_REPORT: rep_q  <= pwdata[15:0];
				nntt_pkg::REG_REMOVE: rem_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			nntt_pkg::REG_GATE:   prdata = {30'd0, gate_q};
			nntt_pkg::REG_REPORT: prdata = {48'd0, rep_q};
			nntt_pkg::REG_REMOVE: prdata = {48'd0, rem_q};
			default:              prdata = '0;
		endcase
	end

	nntt_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_busy, .st,
		.in_ready(s_axis_tready), .cmd
	);

	nntt_dpath #(.TRACKS(TRACKS), .PENDING(PENDING), .MAX_RES(32)) u_dp (
		.clk, .arst_n, .cmd, .st,
		.in_op(s_axis_tuser), .in_x(s_axis_tdata[15:0]),
		.in_y(s_axis_tdata[31:16]), .in_z(s_axis_tdata[47:32]),
		.in_fe(s_axis_tlast),
		.gate_sq(gate_q), .report_age(rep_q), .remove_age(rem_q),
		.out_valid(raw_valid), .out_ready(m_axis_tready),
		.out_data(raw_data), .out_user(raw_user), .out_last(raw_last),
		.out_busy
	);

	assign m_axis_tvalid = raw_valid;
	assign m_axis_tdata  = raw_data;
	assign m_axis_tuser  = raw_user;
	assign m_axis_tlast  = raw_last;

endmodule

// ----- hdl/nntt_ctrl.sv -----
// Controller state machine of the track table.
`timescale 1ns / 1ps
module nntt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_busy,
	input  nntt_pkg::stat_t  st,
	output logic             in_ready,
	output nntt_pkg::cmd_t   cmd
);

	nntt_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= nntt_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nntt_pkg::ST_IDLE: begin
				if (in_fire) state_nx = nntt_pkg::ST_MATCH;
			end
			nntt_pkg::ST_MATCH: begin
				unique case (st.op)
					nntt_pkg::OP_DETECT: state_nx = nntt_pkg::ST_SCAN;
					nntt_pkg::OP_REPORT: state_nx = nntt_pkg::ST_PURGE;
					default:             state_nx = nntt_pkg::ST_IDLE;
				endcase
			end
			nntt_pkg::ST_SCAN: begin
				if (st.scan_end) state_nx = nntt_pkg::ST_CLOSE;
			end
			nntt_pkg::ST_CLOSE: begin
				if (!st.frame_end || st.close_end) state_nx = nntt_pkg::ST_IDLE;
			end
			nntt_pkg::ST_PURGE: begin
				if (st.purge_end) state_nx = nntt_pkg::ST_EMIT;
			end
			nntt_pkg::ST_EMIT: begin
				if (!out_busy) begin
					if (st.emit_end)
						state_nx = st.emitted_any ? nntt_pkg::ST_WAIT : nntt_pkg::ST_EMPTY;
				end
			end
			nntt_pkg::ST_EMPTY: begin
				if (!out_busy) state_nx = nntt_pkg::ST_WAIT;
			end
			nntt_pkg::ST_WAIT: begin
				if (!out_busy) state_nx = nntt_pkg::ST_IDLE;
			end
			default: state_nx = nntt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			nntt_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_fire;
				cmd.scan_clr  = in_fire;
			end
			nntt_pkg::ST_MATCH: begin
				cmd.tick = (st.op == nntt_pkg::OP_TICK);
			end
			nntt_pkg::ST_SCAN: begin
				cmd.scan_step = !st.scan_end;
				cmd.do_match  = st.scan_end;
			end
			nntt_pkg::ST_CLOSE: begin
				cmd.close_step = st.frame_end && !st.close_end;
			end
			nntt_pkg::ST_PURGE: begin
				cmd.purge_step = !st.purge_end;
				cmd.purge_done = st.purge_end;
			end
			nntt_pkg::ST_EMIT: begin
				if (!out_busy && !st.emit_end) begin
					cmd.emit_step = 1'b1;
					cmd.emit_load = st.emit_hit;
				end
			end
			nntt_pkg::ST_EMPTY: begin
				cmd.emit_empty = !out_busy;
			end
			nntt_pkg::ST_WAIT: ;
			default: ;
		endcase
	end

endmodule

// ----- hdl/nntt_dpath.sv -----
// Datapath of the track table: storage, distance unit, output register.
`timescale 1ns / 1ps
module nntt_dpath #(
	parameter int unsigned TRACKS  = 32,
	parameter int unsigned PENDING = 32,
	parameter int unsigned MAX_RES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nntt_pkg::cmd_t    cmd,
	output nntt_pkg::stat_t   st,
	input  logic [1:0]        in_op,
	input  logic [15:0]       in_x,
	input  logic [15:0]       in_y,
	input  logic [15:0]       in_z,
	input  logic              in_fe,
	input  logic [33:0]       gate_sq,
	input  logic [15:0]       report_age,
	input  logic [15:0]       remove_age,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       out_data,
	output logic              out_user,
	output logic              out_last,
	output logic              out_busy
);

	localparam int unsigned TW = $clog2(TRACKS);
	localparam int unsigned CW = $clog2(TRACKS + 1);
	localparam int unsigned PW = (PENDING > 1) ? $clog2(PENDING) : 1;
	localparam int unsigned PCW = $clog2(PENDING + 1);
	localparam int unsigned RW = $clog2(MAX_RES + 1);

	logic [15:0] ident_m [TRACKS];
	logic [47:0] pos_m   [TRACKS];
	logic [31:0] seen_m  [TRACKS];
	logic [47:0] pend_m  [PENDING];

	logic [CW-1:0]  count_q, idx_q, wr_q, last_rec_q;
	logic [PCW-1:0] pcount_q, pidx_q;
	logic [15:0]    next_id_q;
	logic [31:0]    now_q;
	logic [1:0]     op_q;
	logic [47:0]    det_q;
	logic           fe_q;
	logic [33:0]    best_q;
	logic           found_q;
	logic [TW-1:0]  best_i_q;
	logic [RW-1:0]  nres_q, nrec_q;

	logic [TW-1:0] ti;
	logic [47:0]   tp;
	logic [31:0]   age;
	logic signed [16:0] dx, dy, dz;
	logic [15:0]   ax, ay, az;
	logic [31:0]   px, py, pz;
	logic [33:0]   dist_sq;

	assign ti  = idx_q[TW-1:0];
	assign tp  = pos_m[ti];
	assign age = now_q - seen_m[ti];
	assign dx  = $signed({det_q[15], det_q[15:0]})  - $signed({tp[15], tp[15:0]});
	assign dy  = $signed({det_q[31], det_q[31:16]}) - $signed({tp[31], tp[31:16]});
	assign dz  = $signed({det_q[47], det_q[47:32]}) - $signed({tp[47], tp[47:32]});
	// magnitudes fit in 16 bits, so each square is a 16 x 16 product
	assign ax  = dx[16] ? 16'(-dx) : dx[15:0];
	assign ay  = dy[16] ? 16'(-dy) : dy[15:0];
	assign az  = dz[16] ? 16'(-dz) : dz[15:0];
	assign px  = {16'd0, ax} * {16'd0, ax};
	assign py  = {16'd0, ay} * {16'd0, ay};
	assign pz  = {16'd0, az} * {16'd0, az};
	assign dist_sq = {2'b00, px} + {2'b00, py} + {2'b00, pz};

	assign st.scan_end    = (idx_q == count_q);
	assign st.frame_end   = fe_q;
	assign st.close_end   = (pidx_q == pcount_q);
	assign st.purge_end   = (idx_q == count_q);
	assign st.emit_end    = (idx_q == count_q) || (nres_q == RW'(MAX_RES));
	assign st.emit_hit    = (age < {16'd0, report_age});
	assign st.emitted_any = (nres_q != '0);
	assign st.op          = op_q;

	assign out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pcount_q   <= '0;
			next_id_q  <= '0;
			now_q      <= '0;
			idx_q      <= '0;
			wr_q       <= '0;
			last_rec_q <= '0;
			pidx_q     <= '0;
			op_q       <= nntt_pkg::OP_NONE;
			fe_q       <= 1'b0;
			found_q    <= 1'b0;
			nres_q     <= '0;
			nrec_q     <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.emit_load || cmd.emit_empty) out_valid <= 1'b1;
			else if (out_valid && out_ready)     out_valid <= 1'b0;
			if (cmd.load_item) begin
				op_q       <= in_op;
				fe_q       <= in_fe;
				det_q      <= {in_z, in_y, in_x};
				idx_q      <= '0;
				wr_q       <= '0;
				last_rec_q <= '0;
				pidx_q     <= '0;
				nres_q     <= '0;
				nrec_q     <= '0;
			end
			if (cmd.scan_clr) begin
				best_q  <= gate_sq;
				found_q <= 1'b0;
			end
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.scan_step) begin
				if (dist_sq < best_q) begin
					best_q   <= dist_sq;
					best_i_q <= ti;
					found_q  <= 1'b1;
				end
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.do_match) begin
				if (found_q) begin
					pos_m[best_i_q]  <= det_q;
					seen_m[best_i_q] <= now_q;
				end else if (pcount_q != PCW'(PENDING)) begin
					pend_m[pcount_q[PW-1:0]] <= det_q;
					pcount_q <= pcount_q + PCW'(1);
				end
			end
			if (cmd.close_step) begin
				if (count_q != CW'(TRACKS)) begin
					ident_m[count_q[TW-1:0]] <= next_id_q;
					pos_m[count_q[TW-1:0]]   <= pend_m[pidx_q[PW-1:0]];
					seen_m[count_q[TW-1:0]]  <= now_q;
					count_q   <= count_q + CW'(1);
					next_id_q <= next_id_q + 16'd1;
				end
				// empty the buffer after its final entry
				if (pidx_q + PCW'(1) == pcount_q) begin
					pcount_q <= '0;
					pidx_q   <= '0;
				end else begin
					pidx_q <= pidx_q + PCW'(1);
				end
			end
			if (cmd.purge_step) begin
				if (age < {16'd0, remove_age}) begin
					ident_m[wr_q[TW-1:0]] <= ident_m[ti];
					pos_m[wr_q[TW-1:0]]   <= tp;
					seen_m[wr_q[TW-1:0]]  <= seen_m[ti];
					wr_q <= wr_q + CW'(1);
					// remember where the final reported track lands
					if (age < {16'd0, report_age} && nrec_q != RW'(MAX_RES)) begin
						last_rec_q <= wr_q;
						nrec_q     <= nrec_q + RW'(1);
					end
				end
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.purge_done) begin
				count_q <= wr_q;
				idx_q   <= '0;
			end
			if (cmd.emit_step) idx_q <= idx_q + CW'(1);
			if (cmd.emit_load) begin
				out_data  <= {tp, ident_m[ti]};
				out_user  <= 1'b0;
				nres_q    <= nres_q + RW'(1);
				out_last  <= (idx_q == last_rec_q);
			end
			if (cmd.emit_empty) begin
				out_data  <= '0;
				out_user  <= 1'b1;
				out_last  <= 1'b1;
			end
		end
	end

endmodule

// ----- hdl/nntt_checker.sv -----
// Port-level checks of the track table, bound to the top level.
`timescale 1ns / 1ps
module nntt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tuser,
	input logic m_axis_tlast,
	input logic [63:0] m_axis_tdata
);
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("empty report item malformed");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while report pending");
endmodule

bind nearest_neighbour_track_table_core nntt_checker u_chk (
	.clk, .arst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tuser, .m_axis_tlast, .m_axis_tdata
);
